[sv/dhf_pkg.sv]
// Shared constants and pipeline control type for the dual height filter.
package dhf_pkg;

  localparam int WINDOW_DEF      = 100;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int          CFG_BITS    = 4;
  localparam logic [3:0]  SHIFT_MIN   = 4'd1;
  localparam logic [3:0]  SHIFT_MAX   = 4'd8;
  localparam logic [3:0]  SHIFT_RESET = 4'd4;

  // Extra accumulator headroom over a sample: covers the largest shift.
  localparam int ACC_EXTRA = 8;

  typedef struct packed {
    logic ld1;     // beat accepted: sample and ring read enter stage 1
    logic ld2;     // stage 1 -> 2: running sum update
    logic ld3;     // stage 2 -> 3: reciprocal multiply
    logic ld4;     // stage 3 -> 4: leaky integrator update
    logic ld_out;  // stage 4 -> output register
  } pipe_ctl_t;

endpackage

[sv/dhf_ring.sv]
// Sample ring memory with per-entry valid bits; unwritten entries read as zero.
module dhf_ring #(
  parameter int WINDOW      = dhf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = dhf_pkg::SAMPLE_BITS_DEF,
  parameter int AW          = $clog2(WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [AW-1:0]          addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  output logic [SAMPLE_BITS-1:0] rd_data
);
  import dhf_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [WINDOW];
  logic [WINDOW-1:0]      vld_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   rd_vld_r;

  // Read and write share the address: the read returns the entry being replaced.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rd_data_r <= mem[addr];
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else if (wr_en) begin
      rd_vld_r    <= vld_r[addr];
      vld_r[addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[sv/dhf_lane.sv]
// One channel datapath: running sum, divide by window, leaky integrator.
module dhf_lane #(
  parameter int WINDOW      = dhf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = dhf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dhf_pkg::pipe_ctl_t         ctl,
  input  logic [dhf_pkg::CFG_BITS-1:0] shift,
  input  logic [SAMPLE_BITS-1:0]     in_sample,
  input  logic [SAMPLE_BITS-1:0]     old_sample,
  output logic [SAMPLE_BITS-1:0]     fast,
  output logic [SAMPLE_BITS-1:0]     slow
);
  import dhf_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int REC_K = SUM_W + $clog2(WINDOW);
  localparam longint REC_M = ((64'd1 << REC_K) + longint'(WINDOW) - 1) / WINDOW;
  localparam int PW    = REC_K + SAMPLE_BITS;
  localparam int AW    = SAMPLE_BITS + ACC_EXTRA;

  logic [SAMPLE_BITS-1:0] new_r;
  logic [SUM_W-1:0]       sum_r;
  logic [PW-1:0]          prod_r;
  logic [SAMPLE_BITS-1:0] fast4_r;
  logic [AW-1:0]          acc_r;
  logic [AW-1:0]          acc_nxt;
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] fast_r;
  logic [SAMPLE_BITS-1:0] slow_r;
  logic [AW-1:0]          acc_sh;

  // Reciprocal is exact for every sum below 2^SUM_W, so no correction step.
  assign quot    = prod_r[REC_K +: SAMPLE_BITS];
  assign acc_nxt = acc_r - (acc_r >> shift) + AW'(quot);
  assign acc_sh  = acc_r >> shift;

  always_ff @(posedge clk) begin
    if (ctl.ld1) new_r <= in_sample;
    if (ctl.ld3) prod_r <= PW'(sum_r) * PW'(REC_M);
    if (ctl.ld4) fast4_r <= quot;
    if (ctl.ld_out) begin
      fast_r <= fast4_r;
      slow_r <= acc_sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      acc_r <= '0;
    end else begin
      if (ctl.ld2) sum_r <= sum_r - SUM_W'(old_sample) + SUM_W'(new_r);
      if (ctl.ld4) acc_r <= acc_nxt;
    end
  end

  assign fast = fast_r;
  assign slow = slow_r;

endmodule

[sv/dual_height_fir_iir_filter_core.sv]
// Dual height filter top: handshake control, ring position, shift register.
// Throughput: one beat per cycle while out_stall is low; an accepted beat
// moves through v1_r, v2_r, v3_r, v4_r and ov_r. The ring memory reads and
// writes the same entry in the accept cycle; the five-register pipeline
// holds under stall. Reset: synchronous on rst_n; rings read as zero, sums,
// accumulators and ring position clear, smoothing shift returns to 4.
module dual_height_fir_iir_filter_core #(
  parameter int WINDOW      = dhf_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = dhf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       in_left_sample,
  input  logic [SAMPLE_BITS-1:0]       in_right_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SAMPLE_BITS-1:0]       out_left_fast,
  output logic [SAMPLE_BITS-1:0]       out_right_fast,
  output logic [SAMPLE_BITS-1:0]       out_left_slow,
  output logic [SAMPLE_BITS-1:0]       out_right_slow,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dhf_pkg::CFG_BITS-1:0] cfg_data
);
  import dhf_pkg::*;

  localparam int PAW = $clog2(WINDOW);

  logic [PAW-1:0]      pos_r;
  logic [PAW-1:0]      pos_nxt;
  logic [CFG_BITS-1:0] shift_r;
  logic [CFG_BITS-1:0] eff_shift;
  logic                v1_r, v2_r, v3_r, v4_r, ov_r;
  logic                rdy1, rdy2, rdy3, rdy4, rdy_out;
  pipe_ctl_t           ctl;
  logic [SAMPLE_BITS-1:0] left_old, right_old;

  // Each stage takes a beat when it is empty or its content moves on.
  assign rdy_out    = !ov_r || !out_stall;
  assign ctl.ld_out = v4_r && rdy_out;
  assign rdy4       = !v4_r || ctl.ld_out;
  assign ctl.ld4    = v3_r && rdy4;
  assign rdy3       = !v3_r || ctl.ld4;
  assign ctl.ld3    = v2_r && rdy3;
  assign rdy2       = !v2_r || ctl.ld3;
  assign ctl.ld2    = v1_r && rdy2;
  assign rdy1       = !v1_r || ctl.ld2;
  assign ctl.ld1    = in_valid && rdy1;
  assign in_stall   = !rdy1;

  assign cfg_ready = 1'b1;

  always_comb begin
    eff_shift = shift_r;
    if (shift_r < SHIFT_MIN) eff_shift = SHIFT_MIN;
    if (shift_r > SHIFT_MAX) eff_shift = SHIFT_MAX;
  end

  assign pos_nxt = (pos_r == PAW'(WINDOW - 1)) ? '0 : pos_r + PAW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      shift_r <= SHIFT_RESET;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) shift_r <= cfg_data;
      if (ctl.ld1) pos_r <= pos_nxt;
      v1_r <= ctl.ld1 || (v1_r && !ctl.ld2);
      v2_r <= ctl.ld2 || (v2_r && !ctl.ld3);
      v3_r <= ctl.ld3 || (v3_r && !ctl.ld4);
      v4_r <= ctl.ld4 || (v4_r && !ctl.ld_out);
      ov_r <= ctl.ld_out || (ov_r && out_stall);
    end
  end

  dhf_ring #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .AW(PAW)) u_left_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ctl.ld1),
    .addr    (pos_r),
    .wr_data (in_left_sample),
    .rd_data (left_old)
  );

  dhf_ring #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .AW(PAW)) u_right_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ctl.ld1),
    .addr    (pos_r),
    .wr_data (in_right_sample),
    .rd_data (right_old)
  );

  dhf_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_left_lane (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .shift      (eff_shift),
    .in_sample  (in_left_sample),
    .old_sample (left_old),
    .fast       (out_left_fast),
    .slow       (out_left_slow)
  );

  dhf_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_right_lane (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .shift      (eff_shift),
    .in_sample  (in_right_sample),
    .old_sample (right_old),
    .fast       (out_right_fast),
    .slow       (out_right_slow)
  );

  assign out_valid = ov_r;

endmodule

[tb/tb_dual_height_fir_iir_filter_core.sv]
// Self-checking testbench for the dual height filter core: directed, back-pressure and random beats.
module tb_dual_height_fir_iir_filter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dhf_pkg::*;

  localparam int SB         = SAMPLE_BITS_DEF;
  localparam int ACC_BITS   = SAMPLE_BITS_DEF + ACC_EXTRA;
  localparam int SUM_BITS   = 17;
  localparam int LATENCY    = 4;
  localparam int STALL_PCT  = 28;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [SB-1:0] FULL_SCALE = '1;

  // [0] left fast, [1] right fast, [2] left slow, [3] right slow
  typedef logic [3:0][SB-1:0] heights_t;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [SB-1:0]       in_left_sample  = '0;
  logic [SB-1:0]       in_right_sample = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [SB-1:0]       out_left_fast;
  logic [SB-1:0]       out_right_fast;
  logic [SB-1:0]       out_left_slow;
  logic [SB-1:0]       out_right_slow;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data        = '0;

  // Model state of the filter
  logic [SB-1:0]       left_ring  [WINDOW_DEF];
  logic [SB-1:0]       right_ring [WINDOW_DEF];
  int                  ring_pos;
  logic [SUM_BITS-1:0] left_sum, right_sum;
  logic [ACC_BITS-1:0] left_acc, right_acc;
  logic [CFG_BITS-1:0] shift_setting;

  heights_t expected_heights[$];
  string    field_name[4] = '{"left_fast", "right_fast", "left_slow", "right_slow"};
  int       err_count     = 0;
  int       idle_cycles   = 0;
  int       rx_hold_cycles = 0;
  bit       calm          = 1'b0;

  dual_height_fir_iir_filter_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_fast   (out_left_fast),
    .out_right_fast  (out_right_fast),
    .out_left_slow   (out_left_slow),
    .out_right_slow  (out_right_slow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ACC_BITS-1:0] leak_next(input logic [ACC_BITS-1:0] acc,
                                                    input logic [SB-1:0] fast, input int s);
    leak_next = acc - (acc >> s) + ACC_BITS'(fast);
  endfunction

  function automatic logic [SB-1:0] rand_height();
    case ($urandom_range(9))
      0:       rand_height = '0;
      1:       rand_height = FULL_SCALE;
      default: rand_height = SB'($urandom_range(FULL_SCALE));
    endcase
  endfunction

  task automatic predict_heights(input logic [SB-1:0] left, input logic [SB-1:0] right);
    heights_t h;
    int s;
    s = (shift_setting < SHIFT_MIN) ? SHIFT_MIN :
        (shift_setting > SHIFT_MAX) ? SHIFT_MAX : shift_setting;
    left_sum  = left_sum  - SUM_BITS'(left_ring[ring_pos])  + SUM_BITS'(left);
    right_sum = right_sum - SUM_BITS'(right_ring[ring_pos]) + SUM_BITS'(right);
    left_ring[ring_pos]  = left;
    right_ring[ring_pos] = right;
    ring_pos = (ring_pos == WINDOW_DEF - 1) ? 0 : ring_pos + 1;
    h[0] = SB'(left_sum / WINDOW_DEF);
    h[1] = SB'(right_sum / WINDOW_DEF);
    left_acc  = leak_next(left_acc, h[0], s);
    right_acc = leak_next(right_acc, h[1], s);
    h[2] = SB'(left_acc >> s);
    h[3] = SB'(right_acc >> s);
    expected_heights.push_back(h);
  endtask

  task automatic report_mismatch(input string what, input logic [SB-1:0] got,
                                 input logic [SB-1:0] want);
    $display("%0t ns: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // Send one sampling-instant beat; unless calm, idle each cycle ahead of it at random
  task automatic send_sample(input logic [SB-1:0] left, input logic [SB-1:0] right);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_left_sample  <= left;
    in_right_sample <= right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_heights(left, right);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_shift(input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shift_setting = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_extremes();
    send_sample('0, '0);
    send_sample(FULL_SCALE, FULL_SCALE);
    send_sample('0, FULL_SCALE);
    send_sample(FULL_SCALE, '0);
    send_sample(10'h2AA, 10'h155);
    send_sample(10'h155, 10'h2AA);
  endtask

  // Zero must act as the minimum shift, anything above eight as eight
  task automatic test_shift_limits();
    logic [CFG_BITS-1:0] shifts[6] = '{4'd0, 4'd15, SHIFT_MIN, SHIFT_MAX, 4'd9, 4'd2};
    foreach (shifts[i]) begin
      wait_drained();
      write_shift(shifts[i]);
      repeat (3) send_sample(rand_height(), rand_height());
    end
  endtask

  // Fill the ring past one full turn, left at full scale, with no idling on either side
  task automatic test_ring_wrap();
    wait_drained();
    write_shift(SHIFT_MAX);
    calm = 1'b1;
    repeat (WINDOW_DEF + 20) send_sample(FULL_SCALE, rand_height());
    calm = 1'b0;
  endtask

  // Hold the output off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    wait_drained();
    @(posedge clk);
    rx_hold_cycles = 80;
    repeat (40) send_sample(rand_height(), rand_height());
    wait_drained();
  endtask

  task automatic test_random();
    logic [SB-1:0] level;
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_shift(CFG_BITS'($urandom_range(15)));
      level = rand_height();
      repeat (60) begin
        // mostly a noisy level, as a real height sensor gives; the rest anything
        if ($urandom_range(3) != 0)
          send_sample(level ^ SB'($urandom_range(63)), level ^ SB'($urandom_range(63)));
        else
          send_sample(rand_height(), rand_height());
        if ($urandom_range(19) == 0) level = rand_height();
      end
    end
  endtask

  // Receiver: long hold when asked, otherwise random stalls unless calm
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk) begin
    heights_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_right_slow, out_left_slow, out_right_fast, out_left_fast};
      if (expected_heights.size() == 0) begin
        report_mismatch("result beat with nothing expected, left_fast", got[0], '0);
      end else begin
        want = expected_heights.pop_front();
        for (int f = 0; f < 4; f++)
          if (got[f] !== want[f]) report_mismatch(field_name[f], got[f], want[f]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_dual_height_fir_iir_filter_core: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (left_ring[i]) begin
      left_ring[i]  = '0;
      right_ring[i] = '0;
    end
    ring_pos      = 0;
    left_sum      = '0;
    right_sum     = '0;
    left_acc      = '0;
    right_acc     = '0;
    shift_setting = SHIFT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_shift_limits();
    test_ring_wrap();
    test_backpressure();
    test_random();
    wait_drained();

    if (err_count == 0) begin
      $display("tb_dual_height_fir_iir_filter_core: done, clean");
    end else begin
      $display("tb_dual_height_fir_iir_filter_core: done, errors");
    end
    $finish;
  end

endmodule
